// ----- hdl/c_style_token_lexer_unit_macros.svh -----
// assertion macros shared by the lexer rtl
`ifndef C_STYLE_TOKEN_LEXER_UNIT_MACROS_SVH
`define C_STYLE_TOKEN_LEXER_UNIT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define CSTL_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define CSTL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/cstl_pkg.sv -----
// shared types and constants of the c-style token lexer
package cstl_pkg;

	localparam int OFFSET_WIDTH_DEF = 20;
	localparam int LENGTH_WIDTH_DEF = 16;
	localparam int KIND_W           = 6;

	// token kinds
	localparam logic [KIND_W-1:0] KIND_LT      = 6'd12;
	localparam logic [KIND_W-1:0] KIND_GT      = 6'd13;
	localparam logic [KIND_W-1:0] KIND_SLASH   = 6'd15;
	localparam logic [KIND_W-1:0] KIND_BANG    = 6'd21;
	localparam logic [KIND_W-1:0] KIND_ASSIGN  = 6'd22;
	localparam logic [KIND_W-1:0] KIND_EQ      = 6'd23;
	localparam logic [KIND_W-1:0] KIND_NE      = 6'd24;
	localparam logic [KIND_W-1:0] KIND_STRING  = 6'd25;
	localparam logic [KIND_W-1:0] KIND_LE      = 6'd26;
	localparam logic [KIND_W-1:0] KIND_GE      = 6'd27;
	localparam logic [KIND_W-1:0] KIND_IDENT   = 6'd28;
	localparam logic [KIND_W-1:0] KIND_INT     = 6'd29;
	localparam logic [KIND_W-1:0] KIND_INVALID = 6'd31;
	localparam logic [KIND_W-1:0] KIND_EOF     = 6'd32;

	// output queue
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	// which token slots the core filled for the current byte
	typedef struct packed {
		logic a;
		logic b;
	} tok_vld_t;

endpackage

// ----- hdl/cstl_core.sv -----
// lexer state and per-byte token decode
module cstl_core #(
	parameter int OFFSET_WIDTH = cstl_pkg::OFFSET_WIDTH_DEF,
	parameter int LENGTH_WIDTH = cstl_pkg::LENGTH_WIDTH_DEF,
	localparam int TOK_W = cstl_pkg::KIND_W + 2 * OFFSET_WIDTH + LENGTH_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_acc,
	input  logic [7:0]       text_byte,
	output cstl_pkg::tok_vld_t tok_vld,
	output logic [TOK_W-1:0] tok_a,
	output logic [TOK_W-1:0] tok_b
);
	import cstl_pkg::*;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	localparam logic [2:0] OP_SLASH = 3'd4;

	typedef enum logic [2:0] {
		M_IDLE, M_IDENT, M_INT, M_STRING, M_COMMENT, M_PENDING
	} mode_t;

	// {hit, kind} for one-byte punctuation
	function automatic logic [KIND_W:0] single_lookup(input logic [7:0] ch);
		unique case (ch)
			8'h7B:   single_lookup = {1'b1, 6'd0};
			8'h7D:   single_lookup = {1'b1, 6'd1};
			8'h28:   single_lookup = {1'b1, 6'd2};
			8'h29:   single_lookup = {1'b1, 6'd3};
			8'h26:   single_lookup = {1'b1, 6'd4};
			8'h2A:   single_lookup = {1'b1, 6'd5};
			8'h5B:   single_lookup = {1'b1, 6'd6};
			8'h5D:   single_lookup = {1'b1, 6'd7};
			8'h27:   single_lookup = {1'b1, 6'd8};
			8'h3A:   single_lookup = {1'b1, 6'd10};
			8'h3B:   single_lookup = {1'b1, 6'd11};
			8'h2C:   single_lookup = {1'b1, 6'd14};
			8'h7C:   single_lookup = {1'b1, 6'd16};
			8'h2E:   single_lookup = {1'b1, 6'd17};
			8'h23:   single_lookup = {1'b1, 6'd18};
			8'h2D:   single_lookup = {1'b1, 6'd19};
			8'h2B:   single_lookup = {1'b1, 6'd20};
			default: single_lookup = {1'b0, KIND_INVALID};
		endcase
	endfunction

	// {hit, code} for operators that wait on the next byte
	function automatic logic [3:0] op_lookup(input logic [7:0] ch);
		unique case (ch)
			8'h3C:   op_lookup = {1'b1, 3'd0};
			8'h3E:   op_lookup = {1'b1, 3'd1};
			8'h21:   op_lookup = {1'b1, 3'd2};
			8'h3D:   op_lookup = {1'b1, 3'd3};
			CH_SLASH: op_lookup = {1'b1, OP_SLASH};
			default: op_lookup = 4'b0000;
		endcase
	endfunction

	function automatic logic [KIND_W-1:0] op_single(input logic [2:0] op);
		unique case (op)
			3'd0:    op_single = KIND_LT;
			3'd1:    op_single = KIND_GT;
			3'd2:    op_single = KIND_BANG;
			3'd3:    op_single = KIND_ASSIGN;
			default: op_single = KIND_SLASH;
		endcase
	endfunction

	function automatic logic [KIND_W-1:0] op_double(input logic [2:0] op);
		unique case (op)
			3'd0:    op_double = KIND_LE;
			3'd1:    op_double = KIND_GE;
			3'd2:    op_double = KIND_NE;
			3'd3:    op_double = KIND_EQ;
			default: op_double = 6'd0;
		endcase
	endfunction

	mode_t                    mode_q, n_mode;
	logic [2:0]               pend_q, n_pend;
	logic [OFFSET_WIDTH-1:0]  start_q, n_start;
	logic [LENGTH_WIDTH-1:0]  cnt_q, n_cnt;
	logic [OFFSET_WIDTH-1:0]  tline_q, n_tline;
	logic [OFFSET_WIDTH-1:0]  pos_q, n_pos;
	logic [OFFSET_WIDTH-1:0]  line_q, n_line;

	logic [OFFSET_WIDTH-1:0]  pos_inc, line_inc;
	logic [LENGTH_WIDTH-1:0]  cnt_inc;
	logic                     is_digit, is_alpha, is_id, is_ws, is_nl;
	logic [KIND_W:0]          single_hit;
	logic [3:0]               op_hit;
	logic [2:0]               op_cur;
	logic                     idle_emit;

	logic                     close_v, run_idle, eof;
	logic [KIND_W-1:0]        close_kind;
	logic [LENGTH_WIDTH-1:0]  close_len;
	logic [TOK_W-1:0]         close_tok, sec_tok;
	logic                     sec_v;

	assign pos_inc  = (&pos_q)  ? pos_q  : pos_q + 1'b1;
	assign line_inc = (&line_q) ? line_q : line_q + 1'b1;
	assign cnt_inc  = (&cnt_q)  ? cnt_q  : cnt_q + 1'b1;

	assign is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
	assign is_alpha = ((text_byte >= 8'h61) && (text_byte <= 8'h7A))
		|| ((text_byte >= 8'h41) && (text_byte <= 8'h5A));
	assign is_id    = is_digit || is_alpha || (text_byte == CH_UNDER);
	assign is_ws    = (text_byte == CH_SP) || (text_byte == CH_TAB) || (text_byte == CH_CR);
	assign is_nl    = (text_byte == CH_LF);

	assign single_hit = single_lookup(text_byte);
	assign op_hit     = op_lookup(text_byte);
	assign op_cur     = (pend_q <= OP_SLASH) ? pend_q : 3'd0;

	// a byte that is handled from idle and yields a one-byte token
	assign idle_emit = !(is_ws || is_nl || is_id || (text_byte == CH_QUOTE) || op_hit[3]);

	always_comb begin
		n_mode     = mode_q;
		n_pend     = pend_q;
		n_start    = start_q;
		n_cnt      = cnt_q;
		n_tline    = tline_q;
		n_pos      = pos_inc;
		n_line     = line_q;
		close_v    = 1'b0;
		close_kind = KIND_IDENT;
		close_len  = cnt_q;
		run_idle   = 1'b0;
		eof        = 1'b0;

		if (text_byte == CH_NUL) begin
			eof = 1'b1;
			unique case (mode_q)
				M_IDENT: begin
					close_v    = 1'b1;
					close_kind = KIND_IDENT;
				end
				M_INT: begin
					close_v    = 1'b1;
					close_kind = KIND_INT;
				end
				M_STRING: begin
					close_v    = 1'b1;
					close_kind = KIND_STRING;
				end
				M_PENDING: begin
					close_v    = 1'b1;
					close_kind = op_single(op_cur);
					close_len  = LENGTH_WIDTH'(1);
				end
				default: close_v = 1'b0;
			endcase
			n_mode  = M_IDLE;
			n_pend  = '0;
			n_start = '0;
			n_cnt   = '0;
			n_tline = '0;
			n_pos   = '0;
			n_line  = '0;
		end else begin
			unique case (mode_q)
				M_IDENT, M_INT: begin
					if ((mode_q == M_IDENT) ? is_id : is_digit) begin
						n_cnt = cnt_inc;
					end else begin
						close_v    = 1'b1;
						close_kind = (mode_q == M_IDENT) ? KIND_IDENT : KIND_INT;
						run_idle   = 1'b1;
					end
				end
				M_STRING: begin
					if (text_byte == CH_QUOTE) begin
						close_v    = 1'b1;
						close_kind = KIND_STRING;
						n_mode     = M_IDLE;
					end else begin
						if (is_nl) n_line = line_inc;
						n_cnt = cnt_inc;
					end
				end
				M_COMMENT: begin
					if (is_nl || (text_byte == CH_CR)) run_idle = 1'b1;
				end
				M_PENDING: begin
					if ((op_cur != OP_SLASH) && (text_byte == CH_EQ)) begin
						close_v    = 1'b1;
						close_kind = op_double(op_cur);
						close_len  = LENGTH_WIDTH'(2);
						n_mode     = M_IDLE;
					end else if ((op_cur == OP_SLASH) && (text_byte == CH_SLASH)) begin
						n_mode = M_COMMENT;
					end else begin
						close_v    = 1'b1;
						close_kind = op_single(op_cur);
						close_len  = LENGTH_WIDTH'(1);
						run_idle   = 1'b1;
					end
				end
				default: run_idle = 1'b1;
			endcase

			if (run_idle) begin
				n_mode = M_IDLE;
				if (is_nl) n_line = line_inc;
				if (is_id) begin
					n_mode  = is_digit ? M_INT : M_IDENT;
					n_start = pos_q;
					n_cnt   = LENGTH_WIDTH'(1);
					n_tline = line_q;
				end else if (text_byte == CH_QUOTE) begin
					n_mode  = M_STRING;
					n_start = pos_inc;
					n_cnt   = '0;
					n_tline = line_q;
				end else if (op_hit[3]) begin
					n_mode  = M_PENDING;
					n_pend  = op_hit[2:0];
					n_start = pos_q;
					n_tline = line_q;
				end
			end
		end
	end

	assign close_tok = {tline_q, close_len, start_q, close_kind};
	assign sec_tok   = eof ? {line_q, LENGTH_WIDTH'(0), pos_q, KIND_EOF}
		: {line_q, LENGTH_WIDTH'(1), pos_q, single_hit[KIND_W-1:0]};
	assign sec_v     = eof || (run_idle && idle_emit);

	assign tok_a     = close_v ? close_tok : sec_tok;
	assign tok_b     = sec_tok;
	assign tok_vld.a = close_v || sec_v;
	assign tok_vld.b = close_v && sec_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pend_q  <= '0;
			start_q <= '0;
			cnt_q   <= '0;
			tline_q <= '0;
			pos_q   <= '0;
			line_q  <= '0;
		end else if (in_acc) begin
			mode_q  <= n_mode;
			pend_q  <= n_pend;
			start_q <= n_start;
			cnt_q   <= n_cnt;
			tline_q <= n_tline;
			pos_q   <= n_pos;
			line_q  <= n_line;
		end
	end

endmodule

// ----- hdl/c_style_token_lexer_unit.sv -----
// c-style token lexer top level: byte stream in, token stream out
// a byte's words are queued at the edge that takes it; m_tdata shows the queue head
// one byte per cycle while ready; a byte closing a token and emitting another gives two words
// s_tready drops while fewer than two slots of the four-word output queue are free
// reset: arst_n asynchronously clears lexer mode, offsets, line count and queue pointers
// a zero byte closes any open token, emits end of text and returns the lexer to its reset state
`include "c_style_token_lexer_unit_macros.svh"

module c_style_token_lexer_unit #(
	parameter int OFFSET_WIDTH = cstl_pkg::OFFSET_WIDTH_DEF,
	parameter int LENGTH_WIDTH = cstl_pkg::LENGTH_WIDTH_DEF,
	localparam int TOK_W   = cstl_pkg::KIND_W + 2 * OFFSET_WIDTH + LENGTH_WIDTH,
	localparam int TDATA_W = ((TOK_W + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	// input byte stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // text_byte
	// token stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // token_kind, start_offset, token_length, line_number
	output logic               m_tlast    // last_of_run
);
	import cstl_pkg::*;

	logic               in_acc;
	tok_vld_t           vld;
	logic [TOK_W-1:0]   tok_a, tok_b;

	// queue entry: {last_of_run, token word}
	logic [TOK_W:0]     mem_q [Q_DEPTH];
	logic [Q_AW-1:0]    wr_q, rd_q;
	logic [Q_AW:0]      cnt_q;
	logic [Q_AW:0]      push_n;
	logic               pop;

	assign in_acc = s_tvalid && s_tready;

	// lexer state lives in the core; it decodes each byte into up to two token words
	cstl_core #(
		.OFFSET_WIDTH(OFFSET_WIDTH),
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_acc    (in_acc),
		.text_byte (s_tdata),
		.tok_vld   (vld),
		.tok_a     (tok_a),
		.tok_b     (tok_b)
	);

	// room for the worst case of two words must be there before a byte is taken
	assign s_tready = (cnt_q <= (Q_AW + 1)'(Q_DEPTH - 2));

	assign pop    = m_tvalid && m_tready;
	assign push_n = in_acc ? ((Q_AW + 1)'(vld.a) + (Q_AW + 1)'(vld.b)) : '0;

	// slot a always goes first; slot b is only filled when slot a is
	always_ff @(posedge clk) begin
		if (in_acc && vld.a) mem_q[wr_q] <= {!vld.b, tok_a};
		if (in_acc && vld.b) mem_q[wr_q + 1'b1] <= {1'b1, tok_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push_n[Q_AW-1:0];
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + push_n - (Q_AW + 1)'(pop);
		end
	end

	// queue head drives the output word directly
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = TDATA_W'(mem_q[rd_q][TOK_W-1:0]);
	assign m_tlast  = mem_q[rd_q][TOK_W];

	`CSTL_ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= (Q_AW + 1)'(Q_DEPTH), "queue count overflow")
	`CSTL_ASSERT_ALWAYS(a_ptr_cnt, clk, arst_n, (wr_q - rd_q) == cnt_q[Q_AW-1:0], "queue pointers out of step")
	`CSTL_ASSERT_NEXT(a_eof_word, clk, arst_n, in_acc && (s_tdata == 8'h00), cnt_q != '0, "end of text gave no word")
	`CSTL_ASSERT_NEXT(a_two_words, clk, arst_n, in_acc && vld.b, cnt_q >= (Q_AW + 1)'(2), "second token word lost")

endmodule

// ----- tb/tb_top.sv -----
// testbench of the c-style token lexer: directed and random text checked word by word
`timescale 1ns / 1ps

module tb_top;
	import cstl_pkg::*;

	// field layout of one token word on m_tdata, lowest bits first
	localparam int OFF_W    = OFFSET_WIDTH_DEF;
	localparam int LEN_W    = LENGTH_WIDTH_DEF;
	localparam int TOK_W    = KIND_W + 2 * OFF_W + LEN_W;
	localparam int TDATA_W  = ((TOK_W + 7) / 8) * 8;
	localparam int OFS_LSB  = KIND_W;
	localparam int LEN_LSB  = OFS_LSB + OFF_W;
	localparam int LINE_LSB = LEN_LSB + LEN_W;

	localparam logic [OFF_W-1:0] OFF_MAX = '1;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	// punctuation kinds the package leaves unnamed
	localparam logic [KIND_W-1:0] KIND_LBRACE = 6'd0;
	localparam logic [KIND_W-1:0] KIND_RBRACE = 6'd1;
	localparam logic [KIND_W-1:0] KIND_LPAREN = 6'd2;
	localparam logic [KIND_W-1:0] KIND_RPAREN = 6'd3;
	localparam logic [KIND_W-1:0] KIND_AMP    = 6'd4;
	localparam logic [KIND_W-1:0] KIND_STAR   = 6'd5;
	localparam logic [KIND_W-1:0] KIND_LBRACK = 6'd6;
	localparam logic [KIND_W-1:0] KIND_RBRACK = 6'd7;
	localparam logic [KIND_W-1:0] KIND_APOS   = 6'd8;
	localparam logic [KIND_W-1:0] KIND_COLON  = 6'd10;
	localparam logic [KIND_W-1:0] KIND_SEMI   = 6'd11;
	localparam logic [KIND_W-1:0] KIND_COMMA  = 6'd14;
	localparam logic [KIND_W-1:0] KIND_PIPE   = 6'd16;
	localparam logic [KIND_W-1:0] KIND_DOT    = 6'd17;
	localparam logic [KIND_W-1:0] KIND_HASH   = 6'd18;
	localparam logic [KIND_W-1:0] KIND_MINUS  = 6'd19;
	localparam logic [KIND_W-1:0] KIND_PLUS   = 6'd20;

	// bytes with a role of their own in the lexer
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	localparam int MAX_WAIT = 6;

	typedef enum logic [2:0] {
		LX_IDLE, LX_IDENT, LX_INT, LX_STRING, LX_COMMENT, LX_PENDING
	} lex_mode_t;

	// operator held back for one byte of lookahead
	typedef enum logic [2:0] {
		OP_LT, OP_GT, OP_BANG, OP_ASSIGN, OP_SLASH
	} pend_op_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [OFF_W-1:0]  offset;
		logic [LEN_W-1:0]  length;
		logic [OFF_W-1:0]  line;
		logic              last;
	} token_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;   // text_byte
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;   // token_kind, start_offset, token_length, line_number
	logic               m_tlast;   // last_of_run

	c_style_token_lexer_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// lexer state as the predictor sees it
	lex_mode_t        lex_mode;
	pend_op_t         pend_op;
	logic [OFF_W-1:0] tok_start;
	logic [LEN_W-1:0] tok_len;
	logic [OFF_W-1:0] tok_line;
	logic [OFF_W-1:0] byte_pos;
	logic [OFF_W-1:0] cur_line;

	token_t expected_tokens[$];

	int max_gap;       // longest idle stretch before a byte
	int max_stall;     // longest back-pressure stretch before a word
	int stall_left;
	int error_count;
	int bytes_sent;

	// ------------------------------------------------------------------
	// clock and end-of-run guard
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// far beyond the slowest correct run
	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic logic [OFF_W-1:0] sat_off(input logic [OFF_W-1:0] x);
		return (x == OFF_MAX) ? x : x + 1'b1;
	endfunction

	function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] x);
		return (x == LEN_MAX) ? x : x + 1'b1;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic is_name_char(input logic [7:0] b);
		return is_digit(b) || is_alpha(b) || b == CH_UNDER;
	endfunction

	function automatic logic is_op_char(input logic [7:0] b);
		return b == "<" || b == ">" || b == "!" || b == CH_EQ || b == CH_SLASH;
	endfunction

	function automatic pend_op_t op_of(input logic [7:0] b);
		case (b)
			"<":      return OP_LT;
			">":      return OP_GT;
			"!":      return OP_BANG;
			CH_EQ:    return OP_ASSIGN;
			default:  return OP_SLASH;
		endcase
	endfunction

	// kind of an operator that was not followed by its second byte
	function automatic logic [KIND_W-1:0] lone_op_kind(input pend_op_t op);
		case (op)
			OP_LT:     return KIND_LT;
			OP_GT:     return KIND_GT;
			OP_BANG:   return KIND_BANG;
			OP_ASSIGN: return KIND_ASSIGN;
			default:   return KIND_SLASH;
		endcase
	endfunction

	// kind of an operator completed by '='
	function automatic logic [KIND_W-1:0] eq_op_kind(input pend_op_t op);
		case (op)
			OP_LT:   return KIND_LE;
			OP_GT:   return KIND_GE;
			OP_BANG: return KIND_NE;
			default: return KIND_EQ;
		endcase
	endfunction

	function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] b);
		case (b)
			"{":     return KIND_LBRACE;
			"}":     return KIND_RBRACE;
			"(":     return KIND_LPAREN;
			")":     return KIND_RPAREN;
			"&":     return KIND_AMP;
			"*":     return KIND_STAR;
			"[":     return KIND_LBRACK;
			"]":     return KIND_RBRACK;
			"'":     return KIND_APOS;
			":":     return KIND_COLON;
			";":     return KIND_SEMI;
			",":     return KIND_COMMA;
			"|":     return KIND_PIPE;
			".":     return KIND_DOT;
			"#":     return KIND_HASH;
			"-":     return KIND_MINUS;
			"+":     return KIND_PLUS;
			default: return KIND_INVALID;
		endcase
	endfunction

	task automatic push_token(input logic [KIND_W-1:0] kind, input logic [OFF_W-1:0] offset,
			input logic [LEN_W-1:0] length, input logic [OFF_W-1:0] line);
		token_t t;
		t.kind   = kind;
		t.offset = offset;
		t.length = length;
		t.line   = line;
		t.last   = 1'b0;
		expected_tokens.push_back(t);
	endtask

	task automatic clear_lexer();
		lex_mode  = LX_IDLE;
		pend_op   = OP_LT;
		tok_start = '0;
		tok_len   = '0;
		tok_line  = '0;
		byte_pos  = '0;
		cur_line  = '0;
	endtask

	// a nonzero byte seen with no token open
	task automatic start_token(input logic [7:0] b, input logic [OFF_W-1:0] p);
		if (b == CH_SP || b == CH_TAB || b == CH_CR) begin
			return;
		end
		if (b == CH_NL) begin
			cur_line = sat_off(cur_line);
		end else if (is_name_char(b)) begin
			lex_mode  = is_digit(b) ? LX_INT : LX_IDENT;
			tok_start = p;
			tok_len   = LEN_W'(1);
			tok_line  = cur_line;
		end else if (b == CH_QUOTE) begin
			// string offset points past the opening quote
			lex_mode  = LX_STRING;
			tok_start = sat_off(p);
			tok_len   = '0;
			tok_line  = cur_line;
		end else if (is_op_char(b)) begin
			lex_mode  = LX_PENDING;
			pend_op   = op_of(b);
			tok_start = p;
			tok_line  = cur_line;
		end else begin
			push_token(punct_kind(b), p, LEN_W'(1), cur_line);
		end
	endtask

	// expected words for one accepted text byte
	task automatic predict_tokens(input logic [7:0] b);
		logic [OFF_W-1:0] p;
		int               n0;
		p  = byte_pos;
		n0 = expected_tokens.size();
		if (b == CH_NUL) begin
			// end of text closes whatever is open, then eof
			case (lex_mode)
				LX_IDENT:   push_token(KIND_IDENT, tok_start, tok_len, tok_line);
				LX_INT:     push_token(KIND_INT, tok_start, tok_len, tok_line);
				LX_STRING:  push_token(KIND_STRING, tok_start, tok_len, tok_line);
				LX_PENDING: push_token(lone_op_kind(pend_op), tok_start, LEN_W'(1), tok_line);
				default: ;
			endcase
			push_token(KIND_EOF, p, '0, cur_line);
			expected_tokens[expected_tokens.size()-1].last = 1'b1;
			clear_lexer();
			return;
		end
		case (lex_mode)
			LX_IDENT, LX_INT: begin
				if (lex_mode == LX_IDENT ? is_name_char(b) : is_digit(b)) begin
					tok_len = sat_len(tok_len);
				end else begin
					// the closing byte is lexed again from idle
					push_token(lex_mode == LX_IDENT ? KIND_IDENT : KIND_INT,
						tok_start, tok_len, tok_line);
					lex_mode = LX_IDLE;
					start_token(b, p);
				end
			end
			LX_STRING: begin
				if (b == CH_QUOTE) begin
					push_token(KIND_STRING, tok_start, tok_len, tok_line);
					lex_mode = LX_IDLE;
				end else begin
					if (b == CH_NL)
						cur_line = sat_off(cur_line);
					tok_len = sat_len(tok_len);
				end
			end
			LX_COMMENT: begin
				if (b == CH_NL || b == CH_CR) begin
					lex_mode = LX_IDLE;
					start_token(b, p);
				end
			end
			LX_PENDING: begin
				if (pend_op != OP_SLASH && b == CH_EQ) begin
					push_token(eq_op_kind(pend_op), tok_start, LEN_W'(2), tok_line);
					lex_mode = LX_IDLE;
				end else if (pend_op == OP_SLASH && b == CH_SLASH) begin
					lex_mode = LX_COMMENT;
				end else begin
					push_token(lone_op_kind(pend_op), tok_start, LEN_W'(1), tok_line);
					lex_mode = LX_IDLE;
					start_token(b, p);
				end
			end
			default: begin
				lex_mode = LX_IDLE;
				start_token(b, p);
			end
		endcase
		byte_pos = sat_off(p);
		if (expected_tokens.size() > n0)
			expected_tokens[expected_tokens.size()-1].last = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// byte sender
	// ------------------------------------------------------------------
	// valid is only ever written once per falling edge
	task automatic send_text_byte(input logic [7:0] b);
		int gap;
		gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		predict_tokens(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_text_byte(s[i]);
	endtask

	// ------------------------------------------------------------------
	// token sink: back-pressure and word check
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_word
		token_t got;
		token_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind   = m_tdata[KIND_W-1:0];
			got.offset = m_tdata[OFS_LSB +: OFF_W];
			got.length = m_tdata[LEN_LSB +: LEN_W];
			got.line   = m_tdata[LINE_LSB +: OFF_W];
			got.last   = m_tlast;
			if (expected_tokens.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("%0t: unexpected word kind %0d offset %0d length %0d line %0d last %0b",
						$realtime, got.kind, got.offset, got.length, got.line, got.last);
			end else begin
				want = expected_tokens.pop_front();
				if (got.kind !== want.kind || got.offset !== want.offset ||
						got.length !== want.length || got.line !== want.line ||
						got.last !== want.last) begin
					error_count++;
					if (error_count <= 10) begin
						$display("%0t: expected kind %0d offset %0d length %0d line %0d last %0b",
							$realtime, want.kind, want.offset, want.length, want.line,
							want.last);
						$display("%0t: got kind %0d offset %0d length %0d line %0d last %0b",
							$realtime, got.kind, got.offset, got.length, got.line, got.last);
					end
				end
			end
			stall_left = (max_stall == 0) ? 0 : $urandom_range(0, max_stall);
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// every punctuation token, unknown bytes and the top-bit range
	task automatic test_punctuation();
		send_text("{}()&*[]':;,|.#-+$@");
		send_text_byte(8'h80);
		send_text_byte(8'hFF);
		send_text_byte(CH_NUL);
	endtask

	// two-byte operators and their lone forms, closed by varied bytes
	task automatic test_operators();
		send_text("<=>=!===<a>1!x=\t<");
		send_text_byte(CH_NUL);
	endtask

	// no block comments: slash star is two tokens; comments end at cr or lf
	task automatic test_comments();
		send_text("/*//c{");
		send_text_byte(CH_CR);
		send_text("}//\n/");
		send_text_byte(CH_NUL);
	endtask

	// the byte that ends a name or a number starts the next token
	task automatic test_names_and_numbers();
		send_text("_a9 12ab 7(x\"s\"");
		send_text_byte(CH_NUL);
	endtask

	// newline inside a string, empty string, unterminated string at end of text
	task automatic test_strings();
		send_text("\"a\nb\"\"\"\n\"op");
		send_text_byte(CH_NUL);
	endtask

	// end of text while a name, a number, each pending operator or a comment is open
	task automatic test_eof_closing();
		string open_text[8] = '{"abc", "42", "<", ">", "!", "=", "/", "//x"};
		foreach (open_text[i]) begin
			send_text(open_text[i]);
			send_text_byte(CH_NUL);
		end
		send_text_byte(CH_NUL);
	endtask

	// long identifier streamed with no gaps on either side
	task automatic test_long_identifier();
		int saved_gap;
		int saved_stall;
		saved_gap   = max_gap;
		saved_stall = max_stall;
		max_gap     = 0;
		max_stall   = 0;
		send_text_byte(CH_UNDER);
		repeat (200)
			send_text_byte("a");
		send_text_byte(CH_SP);
		send_text_byte(CH_NUL);
		max_gap   = saved_gap;
		max_stall = saved_stall;
	endtask

	// well-formed token fragments with random content, plus noise
	task automatic test_random_text();
		string name_chars;
		string punct_chars;
		string op_chars;
		int    first;
		int    pick;
		logic [7:0] b;
		name_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
		punct_chars = "{}()&*[]':;,|.#-+";
		op_chars    = "<>!=/";
		first       = bytes_sent;
		while (bytes_sent - first < 1100) begin
			// switch either side between busy and quiet now and then
			if ($urandom_range(0, 9) == 0)
				max_gap = $urandom_range(0, 1) ? MAX_WAIT : 0;
			if ($urandom_range(0, 9) == 0)
				max_stall = $urandom_range(0, 1) ? MAX_WAIT : 0;
			pick = $urandom_range(0, 99);
			if (pick < 18) begin
				send_text_byte(name_chars[$urandom_range(0, 52)]);
				repeat ($urandom_range(0, 10))
					send_text_byte(name_chars[$urandom_range(0, name_chars.len() - 1)]);
			end else if (pick < 30) begin
				repeat ($urandom_range(1, 8))
					send_text_byte(8'("0" + $urandom_range(0, 9)));
			end else if (pick < 38) begin
				send_text_byte(CH_QUOTE);
				repeat ($urandom_range(0, 10)) begin
					b = ($urandom_range(0, 3) == 0) ? CH_NL : 8'($urandom_range(1, 255));
					if (b != CH_QUOTE)
						send_text_byte(b);
				end
				if ($urandom_range(0, 9) != 0)
					send_text_byte(CH_QUOTE);
			end else if (pick < 44) begin
				send_text("//");
				repeat ($urandom_range(0, 8)) begin
					b = 8'($urandom_range(1, 255));
					if (b != CH_NL && b != CH_CR)
						send_text_byte(b);
				end
				send_text_byte($urandom_range(0, 1) ? CH_NL : CH_CR);
			end else if (pick < 60) begin
				send_text_byte(op_chars[$urandom_range(0, op_chars.len() - 1)]);
				if ($urandom_range(0, 1))
					send_text_byte(CH_EQ);
			end else if (pick < 75) begin
				case ($urandom_range(0, 3))
					0:       send_text_byte(CH_SP);
					1:       send_text_byte(CH_TAB);
					2:       send_text_byte(CH_CR);
					default: send_text_byte(CH_NL);
				endcase
			end else if (pick < 90) begin
				send_text_byte(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
			end else if (pick < 97) begin
				send_text_byte(8'($urandom_range(1, 255)));
			end else begin
				send_text_byte(CH_NUL);
			end
		end
		send_text_byte(CH_NUL);
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		stall_left  = 0;
		error_count = 0;
		bytes_sent  = 0;
		max_gap     = MAX_WAIT;
		max_stall   = MAX_WAIT;
		clear_lexer();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_punctuation();
		test_operators();
		test_comments();
		test_names_and_numbers();
		test_strings();
		test_eof_closing();
		test_long_identifier();
		test_random_text();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		// keep clocking to catch stray words
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
